// File: rtl/core/ddoi_pkg.sv
package ddoi_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries = 24;
  localparam logic [15:0] RadiusReset = 16'd3277;
  localparam logic [15:0] SepReset = 16'd13107;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0] RadToBam = 32'd683565276;

  localparam logic CfgRadius = 1'b0;
  localparam logic CfgSep = 1'b1;

  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: rtl/core/ddoi_cordic.sv
module ddoi_cordic #(
  parameter int unsigned CordicSteps = ddoi_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned Steps =
    (CordicSteps < ddoi_pkg::AtanEntries) ? CordicSteps : ddoi_pkg::AtanEntries;

  logic               busy_q, busy_d;
  logic [4:0]         i_q, i_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic               flip_q, flip_d;
  logic signed [16:0] s;
  logic signed [33:0] dx, dy, at;

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign at = {4'd0, ddoi_pkg::atan_lut(i_q)};

  always_comb begin
    busy_d = busy_q;
    i_d = i_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    flip_d = flip_q;
    done_o = 1'b0;
    s = {angle_i[15], angle_i};
    if (start_i) begin
      flip_d = 1'b0;
      if (s > 17'sd16384) begin
        s = s - 17'sd32768;
        flip_d = 1'b1;
      end else if (s < -17'sd16384) begin
        s = s + 17'sd32768;
        flip_d = 1'b1;
      end
      x_d = ddoi_pkg::CordicGain;
      y_d = '0;
      z_d = {{1{s[16]}}, s, 16'd0};
      i_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(Steps - 1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
        if (flip_q) begin
          x_d = -x_d;
          y_d = -y_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q <= '0;
    end else begin
      busy_q <= busy_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    flip_q <= flip_d;
  end

  assign cos_o = x_q;
  assign sin_o = y_q;

endmodule

// File: rtl/core/ddoi_divider.sv
module ddoi_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [39:0]        num_i,
  input  logic [15:0]        den_i,
  output logic               done_o,
  output logic [39:0]        quo_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [39:0] q_q;
  logic [16:0] rem_q;
  logic [15:0] den_q;
  logic [16:0] trial;
  logic [16:0] shifted;

  assign shifted = {rem_q[15:0], q_q[39]};
  assign trial = shifted - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == 6'd39);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_q <= trial;
        q_q <= {q_q[38:0], 1'b1};
      end else begin
        rem_q <= shifted;
        q_q <= {q_q[38:0], 1'b0};
      end
    end
  end

  assign quo_o = q_q;

endmodule

// File: rtl/core/diff_drive_odometry_integrator_core.sv
// Differential-drive odometry integrator.
// The input channel takes one tick word: left and right wheel speeds (Q7.8)
// and the tick length (Q0.16). The output channel gives one result word per
// tick: the new pose x, y (Q16.16, saturating), heading (binary angle) and
// the forward speed and turn rate (Q16.16).
// Wheel radius and separation are written through the configuration port;
// the user must write them only while the block is idle, and the block
// itself does not enforce this. The one-bit index selects the radius (0)
// or the separation (1). The first step of a tick forms the forward speed
// and starts the serial restoring divider for the turn rate and the CORDIC,
// which runs CORDIC_STEPS iterations, capped at the arctangent table size,
// alongside it; six multiply steps on one shared 34x34 multiplier follow.
// With zero separation the divider is not waited for. One tick is worked on
// at a time; the next is accepted in the cycle after the result is taken.
// The result is held in an output register; while the receiver stalls it
// stays stable and the input stays stalled.
// Reset clears the pose to zero and loads the default radius and
// separation; no result is pending after reset.
module diff_drive_odometry_integrator_core #(
  parameter int unsigned CORDIC_STEPS = ddoi_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] left_wheel_speed_i,
  input  logic signed [15:0] right_wheel_speed_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [15:0]        heading_o,
  output logic signed [31:0] forward_speed_o,
  output logic signed [31:0] turn_rate_o
);

  typedef enum logic [9:0] {
    StIdle = 10'b0000000001,
    StPre  = 10'b0000000010,
    StWait = 10'b0000000100,
    StM1   = 10'b0000001000,
    StM2   = 10'b0000010000,
    StM3   = 10'b0000100000,
    StM4   = 10'b0001000000,
    StM5   = 10'b0010000000,
    StM6   = 10'b0100000000,
    StOut  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [15:0] radius_q, sep_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0] hd_q;
  logic signed [16:0] vl_q, vr_q;
  logic [15:0] dt_q;
  logic signed [33:0] v_q, w_q;
  logic signed [47:0] num_q;
  logic signed [67:0] acc_q;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic cdone_q, ddone_q, cdone, ddone;
  logic start;
  logic signed [33:0] cos_w, sin_w;
  logic [39:0] quo;
  logic [39:0] absnum;
  logic signed [40:0] sq;
  logic signed [47:0] tmp;

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign start = (state_q == StPre);
  assign absnum = num_q[47] ? 40'(-num_q) : 40'(num_q);

  ddoi_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .angle_i(hd_q),
    .done_o(cdone), .cos_o(cos_w), .sin_o(sin_w)
  );

  ddoi_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .num_i(absnum),
    .den_i(sep_q), .done_o(ddone), .quo_o(quo)
  );

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      StIdle: begin ma = '0; mb = '0; end
      StPre: begin ma = 34'(vl_q + vr_q); mb = {18'd0, radius_q}; end
      StM1: begin ma = v_q; mb = cos_w; end
      StM2: begin ma = 34'(acc_q >>> 30); mb = {18'd0, dt_q}; end
      StM3: begin ma = v_q; mb = sin_w; end
      StM4: begin ma = 34'(acc_q >>> 30); mb = {18'd0, dt_q}; end
      StM5: begin ma = w_q; mb = {18'd0, dt_q}; end
      StM6: begin ma = 34'(acc_q >>> 16); mb = {2'd0, ddoi_pkg::RadToBam}; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StPre;
      StPre: state_d = StWait;
      StWait: if ((cdone_q || cdone) && (ddone_q || ddone || sep_q == 16'd0)) state_d = StM1;
      StM1: state_d = StM2;
      StM2: state_d = StM3;
      StM3: state_d = StM4;
      StM4: state_d = StM5;
      StM5: state_d = StM6;
      StM6: state_d = StOut;
      StOut: if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      radius_q <= ddoi_pkg::RadiusReset;
      sep_q <= ddoi_pkg::SepReset;
      px_q <= '0;
      py_q <= '0;
      hd_q <= '0;
      cdone_q <= 1'b0;
      ddone_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ddoi_pkg::CfgRadius) radius_q <= cfg_data_i;
        else radius_q <= radius_q;
        if (cfg_idx_i == ddoi_pkg::CfgSep) sep_q <= cfg_data_i;
      end
      if (start) begin
        cdone_q <= 1'b0;
        ddone_q <= 1'b0;
      end else begin
        if (cdone) cdone_q <= 1'b1;
        if (ddone) ddone_q <= 1'b1;
      end
      if (state_q == StM2) px_q <= ddoi_pkg::sat32(48'(px_q) + 48'(prod >>> 16));
      if (state_q == StM4) py_q <= ddoi_pkg::sat32(48'(py_q) + 48'(prod >>> 16));
      if (state_q == StM6) hd_q <= hd_q + prod[47:32];
    end
  end

  always_comb begin
    sq = num_q[47] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (sep_q == 16'd0) begin
      if (num_q > 0) tmp = 48'sh0000_7FFF_FFFF;
      else if (num_q < 0) tmp = -48'sh0000_8000_0000;
      else tmp = '0;
    end else begin
      tmp = 48'(sq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      vl_q <= 17'(left_wheel_speed_i);
      vr_q <= 17'(right_wheel_speed_i);
      dt_q <= time_step_i;
      num_q <= (48'($signed({1'b0, radius_q})) *
                48'(17'(left_wheel_speed_i) - 17'(right_wheel_speed_i))) <<< 8;
    end
    if (state_q == StPre) v_q <= 34'(prod >>> 9);
    if (state_q == StM1) w_q <= 34'(ddoi_pkg::sat32(tmp));
    if (state_q == StM1 || state_q == StM3 || state_q == StM5) acc_q <= prod;
  end

  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign heading_o = hd_q;
  assign forward_speed_o = v_q[31:0];
  assign turn_rate_o = w_q[31:0];

endmodule
